// ===== sv/sdsl_pkg.sv =====
`timescale 1ns / 1ps
// sdsl_pkg: shared constants, register indexes and the pixel word type
// for the symmetric double-step line rasterizer; no dependencies

package sdsl_pkg;

    // coordinate width default, handed down from the top level
    localparam int COORD_BITS_DEFAULT = 12;

    // fixed port widths
    localparam int PIX_BITS       = 12;
    localparam int ADDR_BITS      = 24;
    localparam int COLOUR_BITS    = 32;
    localparam int WIDTH_BITS     = 13;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 32;

    // item modes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DRAW_COLOUR = 1'd1;

    localparam logic [WIDTH_BITS-1:0]  FRAME_WIDTH_RESET = 13'd320;
    localparam logic [COLOUR_BITS-1:0] DRAW_COLOUR_RESET = 32'd0;

    // pixels produced by one item, held in the front burst register
    localparam int BURST_MAX      = 4;
    localparam int BURST_CNT_BITS = 3;

    // pixel queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    // one pixel on its way to the back part
    typedef struct packed {
        logic [PIX_BITS-1:0] x;
        logic [PIX_BITS-1:0] y;
        logic                last;
        logic                done;
    } pix_t;

endpackage

// ===== sv/sdsl_if.sv =====
`timescale 1ns / 1ps
// sdsl channel interfaces: item input, pixel output and configuration write
// depends on sdsl_pkg

interface sdsl_item_if
    import sdsl_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic                mode;
    logic [PIX_BITS-1:0] x_start;
    logic [PIX_BITS-1:0] y_start;
    logic [PIX_BITS-1:0] x_end;
    logic [PIX_BITS-1:0] y_end;

    modport source (output valid, mode, x_start, y_start, x_end, y_end, input ready);
    modport sink (input valid, mode, x_start, y_start, x_end, y_end, output ready);
endinterface

interface sdsl_pixel_if
    import sdsl_pkg::*;
    ();
    logic                   valid;
    logic                   ready;
    logic [PIX_BITS-1:0]    pixel_x;
    logic [PIX_BITS-1:0]    pixel_y;
    logic [ADDR_BITS-1:0]   pixel_address;
    logic [COLOUR_BITS-1:0] pixel_colour;
    logic                   last_of_run;
    logic                   line_done;

    modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_colour,
                    last_of_run, line_done, input ready);
    modport sink (input valid, pixel_x, pixel_y, pixel_address, pixel_colour,
                  last_of_run, line_done, output ready);
endinterface

interface sdsl_cfg_if
    import sdsl_pkg::*;
    ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/sdsl_front.sv =====
`timescale 1ns / 1ps
// sdsl_front: accepts items, keeps the line state and works out the pixels
// of each item into a burst register that drains into the queue; uses sdsl_pkg

module sdsl_front
    import sdsl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    sdsl_item_if.sink  item,
    output pix_t       push_pix,
    output logic       push_valid,
    input  logic       push_ready
);

    localparam int CB = COORD_BITS;
    localparam int DW = COORD_BITS + 4;
    localparam int PW = COORD_BITS - 2;

    // line state
    logic [CB-1:0]        fwd_major_reg, fwd_minor_reg, back_major_reg, back_minor_reg;
    logic [CB-1:0]        fwd_major_next, fwd_minor_next, back_major_next, back_minor_next;
    logic signed [DW-1:0] decision_reg, incr_one_reg, incr_two_reg, bound_reg;
    logic signed [DW-1:0] decision_next, incr_one_next, incr_two_next, bound_next;
    logic                 minor_neg_reg, swapped_reg, steep_reg, active_reg;
    logic                 minor_neg_next, swapped_next, steep_next, active_next;
    logic [PW-1:0]        passes_reg, passes_next;
    logic [1:0]           leftover_reg, leftover_next;

    // burst of pixels waiting for the queue
    pix_t                      burst_reg [BURST_MAX];
    logic [BURST_CNT_BITS-1:0] burst_cnt_reg;
    pix_t                      new_pix [BURST_MAX];
    logic [BURST_CNT_BITS-1:0] new_cnt;
    logic                      item_fire;

    // start item decode
    logic [CB-1:0]        a1, b1, a2, b2;
    logic signed [CB:0]   ddx, ddy;
    logic [CB-1:0]        adx, ady, mdx, mdy;
    logic                 s_swap, s_neg;
    logic [CB-1:0]        ma1, mb1, ma2, mb2;
    logic [CB-1:0]        s_fm, s_fn, s_bm, s_bn;
    logic [CB-1:0]        dx_m1;
    logic signed [DW-1:0] dx_s, dy_s, s_incr_two, s_bound, s_incr_one, s_decision;
    logic                 s_steep, s_active;

    // step item decode
    logic                 pat_one, pat_four, pat_two, first_moves, second_moves, back_moves;
    logic [CB-1:0]        f1m, f1n, f2m, f2n, b1m, b1n, b2m, b2n, lb1n;
    logic                 pass_done;

    function automatic pix_t to_pix(input logic [CB-1:0] major, input logic [CB-1:0] minor,
                                    input logic swp, input logic last, input logic done);
        pix_t p;
        p.x    = swp ? PIX_BITS'(minor) : PIX_BITS'(major);
        p.y    = swp ? PIX_BITS'(major) : PIX_BITS'(minor);
        p.last = last;
        p.done = done;
        return p;
    endfunction

    function automatic logic [CB-1:0] minor_fwd(input logic [CB-1:0] v, input logic neg);
        return neg ? v - 1'b1 : v + 1'b1;
    endfunction

    function automatic logic [CB-1:0] minor_back(input logic [CB-1:0] v, input logic neg);
        return neg ? v + 1'b1 : v - 1'b1;
    endfunction

    // endpoints, deltas, axis choice and ordering
    always_comb
    begin
        a1  = CB'(item.x_start);
        b1  = CB'(item.y_start);
        a2  = CB'(item.x_end);
        b2  = CB'(item.y_end);
        ddx = $signed({1'b0, a2}) - $signed({1'b0, a1});
        ddy = $signed({1'b0, b2}) - $signed({1'b0, b1});
        adx = ddx[CB] ? CB'(-ddx) : ddx[CB-1:0];
        ady = ddy[CB] ? CB'(-ddy) : ddy[CB-1:0];
        s_neg  = ddx[CB] != ddy[CB];
        s_swap = ady > adx;
        ma1 = s_swap ? b1 : a1;
        mb1 = s_swap ? a1 : b1;
        ma2 = s_swap ? b2 : a2;
        mb2 = s_swap ? a2 : b2;
        mdx = s_swap ? ady : adx;
        mdy = s_swap ? adx : ady;
        if (ma1 > ma2)
        begin
            s_fm = ma2;
            s_fn = mb2;
            s_bm = ma1;
            s_bn = mb1;
        end
        else
        begin
            s_fm = ma1;
            s_fn = mb1;
            s_bm = ma2;
            s_bn = mb2;
        end
        dx_m1      = mdx - 1'b1;
        dx_s       = $signed(DW'(mdx));
        dy_s       = $signed(DW'(mdy));
        s_incr_two = (dy_s <<< 2) - (dx_s <<< 1);
        s_steep    = !s_incr_two[DW-1];
        s_bound    = s_steep ? ((dy_s - dx_s) <<< 1) : (dy_s <<< 1);
        s_incr_one = s_bound <<< 1;
        s_decision = s_steep ? (s_incr_one + dx_s) : (s_incr_one - dx_s);
        s_active   = (dx_m1[CB-1:2] != '0) || (dx_m1[1:0] != 2'd0);
    end

    // pattern choice and cursor moves of one pass
    always_comb
    begin
        pat_one      = !steep_reg && decision_reg[DW-1];
        pat_four     = steep_reg && !decision_reg[DW-1] && (decision_reg != '0);
        pat_two      = !pat_one && !pat_four && (decision_reg < bound_reg);
        first_moves  = !pat_one && !pat_two;
        second_moves = pat_two || pat_four;
        back_moves   = pat_four || (first_moves && !pat_four
                                    && (!steep_reg || decision_reg > bound_reg));
        f1m  = fwd_major_reg + 1'b1;
        f1n  = first_moves ? minor_fwd(fwd_minor_reg, minor_neg_reg) : fwd_minor_reg;
        f2m  = fwd_major_reg + CB'(2);
        f2n  = second_moves ? minor_fwd(f1n, minor_neg_reg) : f1n;
        b1m  = back_major_reg - 1'b1;
        b1n  = first_moves ? minor_back(back_minor_reg, minor_neg_reg) : back_minor_reg;
        b2m  = back_major_reg - CB'(2);
        b2n  = second_moves ? minor_back(b1n, minor_neg_reg) : b1n;
        lb1n = back_moves ? minor_back(back_minor_reg, minor_neg_reg) : back_minor_reg;
        pass_done = (passes_reg == PW'(1)) && (leftover_reg == 2'd0);
    end

    // next line state and the pixels of the item
    always_comb
    begin
        fwd_major_next  = fwd_major_reg;
        fwd_minor_next  = fwd_minor_reg;
        back_major_next = back_major_reg;
        back_minor_next = back_minor_reg;
        decision_next   = decision_reg;
        incr_one_next   = incr_one_reg;
        incr_two_next   = incr_two_reg;
        bound_next      = bound_reg;
        minor_neg_next  = minor_neg_reg;
        swapped_next    = swapped_reg;
        steep_next      = steep_reg;
        passes_next     = passes_reg;
        leftover_next   = leftover_reg;
        active_next     = active_reg;
        new_cnt         = '0;
        for (int i = 0; i < BURST_MAX; i++)
        begin
            new_pix[i] = '0;
        end
        if (item.mode == MODE_START)
        begin
            fwd_major_next  = s_fm;
            fwd_minor_next  = s_fn;
            back_major_next = s_bm;
            back_minor_next = s_bn;
            minor_neg_next  = s_neg;
            swapped_next    = s_swap;
            if (mdx == '0)
            begin
                // zero-length line: one pixel and back to idle
                active_next   = 1'b0;
                passes_next   = '0;
                leftover_next = 2'd0;
                new_pix[0]    = to_pix(s_fm, s_fn, s_swap, 1'b1, 1'b1);
                new_cnt       = BURST_CNT_BITS'(1);
            end
            else
            begin
                passes_next   = dx_m1[CB-1:2];
                leftover_next = dx_m1[1:0];
                incr_two_next = s_incr_two;
                steep_next    = s_steep;
                bound_next    = s_bound;
                incr_one_next = s_incr_one;
                decision_next = s_decision;
                active_next   = s_active;
                new_pix[0]    = to_pix(s_fm, s_fn, s_swap, 1'b0, 1'b0);
                new_pix[1]    = to_pix(s_bm, s_bn, s_swap, 1'b1, !s_active);
                new_cnt       = BURST_CNT_BITS'(2);
            end
        end
        else if (active_reg)
        begin
            if (passes_reg != '0)
            begin
                fwd_major_next  = f2m;
                fwd_minor_next  = f2n;
                back_major_next = b2m;
                back_minor_next = b2n;
                decision_next   = decision_reg
                                  + ((pat_one || pat_four) ? incr_one_reg : incr_two_reg);
                passes_next     = passes_reg - 1'b1;
                active_next     = !pass_done;
                new_pix[0]      = to_pix(f1m, f1n, swapped_reg, 1'b0, 1'b0);
                new_pix[1]      = to_pix(f2m, f2n, swapped_reg, 1'b0, 1'b0);
                new_pix[2]      = to_pix(b1m, b1n, swapped_reg, 1'b0, 1'b0);
                new_pix[3]      = to_pix(b2m, b2n, swapped_reg, 1'b1, pass_done);
                new_cnt         = BURST_CNT_BITS'(4);
            end
            else if (leftover_reg != 2'd0)
            begin
                // tail of one to three pixels
                fwd_major_next = (leftover_reg == 2'd1) ? f1m : f2m;
                fwd_minor_next = (leftover_reg == 2'd1) ? f1n : f2n;
                if (leftover_reg == 2'd3)
                begin
                    back_major_next = b1m;
                    back_minor_next = lb1n;
                end
                leftover_next = 2'd0;
                active_next   = 1'b0;
                new_pix[0]    = to_pix(f1m, f1n, swapped_reg,
                                       leftover_reg == 2'd1, leftover_reg == 2'd1);
                new_pix[1]    = to_pix(f2m, f2n, swapped_reg,
                                       leftover_reg == 2'd2, leftover_reg == 2'd2);
                new_pix[2]    = to_pix(b1m, lb1n, swapped_reg, 1'b1, 1'b1);
                new_cnt       = BURST_CNT_BITS'(leftover_reg);
            end
            else
            begin
                active_next = 1'b0;
            end
        end
    end

    assign push_valid = burst_cnt_reg != '0;
    assign push_pix   = burst_reg[0];
    assign item.ready = (burst_cnt_reg == '0)
                        || ((burst_cnt_reg == BURST_CNT_BITS'(1)) && push_ready);
    assign item_fire  = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_major_reg  <= '0;
            fwd_minor_reg  <= '0;
            back_major_reg <= '0;
            back_minor_reg <= '0;
            decision_reg   <= '0;
            incr_one_reg   <= '0;
            incr_two_reg   <= '0;
            bound_reg      <= '0;
            minor_neg_reg  <= 1'b0;
            swapped_reg    <= 1'b0;
            steep_reg      <= 1'b0;
            passes_reg     <= '0;
            leftover_reg   <= 2'd0;
            active_reg     <= 1'b0;
        end
        else if (item_fire)
        begin
            fwd_major_reg  <= fwd_major_next;
            fwd_minor_reg  <= fwd_minor_next;
            back_major_reg <= back_major_next;
            back_minor_reg <= back_minor_next;
            decision_reg   <= decision_next;
            incr_one_reg   <= incr_one_next;
            incr_two_reg   <= incr_two_next;
            bound_reg      <= bound_next;
            minor_neg_reg  <= minor_neg_next;
            swapped_reg    <= swapped_next;
            steep_reg      <= steep_next;
            passes_reg     <= passes_next;
            leftover_reg   <= leftover_next;
            active_reg     <= active_next;
        end
    end

    // burst count: loaded on accept, counts down as pixels enter the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_cnt_reg <= '0;
        end
        else if (item_fire)
        begin
            burst_cnt_reg <= new_cnt;
        end
        else if (push_valid && push_ready)
        begin
            burst_cnt_reg <= burst_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            for (int i = 0; i < BURST_MAX; i++)
            begin
                burst_reg[i] <= new_pix[i];
            end
        end
        else if (push_valid && push_ready)
        begin
            for (int i = 0; i < BURST_MAX - 1; i++)
            begin
                burst_reg[i] <= burst_reg[i+1];
            end
        end
    end

    // an idle line has no passes or tail left over
    assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (passes_reg == '0 && leftover_reg == 2'd0))
        else $error("idle line with work left");

    assert property (@(posedge clk) disable iff (!rst_n)
        burst_cnt_reg <= BURST_CNT_BITS'(BURST_MAX))
        else $error("burst count out of range");

endmodule

// ===== sv/sdsl_queue.sv =====
`timescale 1ns / 1ps
// sdsl_queue: short pixel queue between the front and back parts
// uses sdsl_pkg

module sdsl_queue
    import sdsl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  pix_t push_pix,
    input  logic push_valid,
    output logic push_ready,
    output pix_t pop_pix,
    output logic pop_valid,
    input  logic pop_ready
);

    pix_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0] cnt_reg;
    logic                 push_fire, pop_fire;

    assign push_ready = cnt_reg != QCNT_BITS'(QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_pix    = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop_fire && !push_fire)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_pix;
        end
    end

    // fill level tracks the pointer distance
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != QCNT_BITS'(QUEUE_DEPTH)) |-> (QPTR_BITS'(wr_ptr_reg - rd_ptr_reg)
                                                  == QPTR_BITS'(cnt_reg)))
        else $error("queue count and pointers disagree");

endmodule

// ===== sv/sdsl_back.sv =====
`timescale 1ns / 1ps
// sdsl_back: takes pixels from the queue, forms the frame address and colour
// and holds the result word in the output register; uses sdsl_pkg

module sdsl_back
    import sdsl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  pix_t                   pop_pix,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  logic [WIDTH_BITS-1:0]  frame_width,
    input  logic [COLOUR_BITS-1:0] draw_colour,
    sdsl_pixel_if.source           pixel
);

    logic                             out_valid_reg;
    logic [PIX_BITS-1:0]              x_reg, y_reg;
    logic [ADDR_BITS-1:0]             addr_reg, addr_next;
    logic [COLOUR_BITS-1:0]           colour_reg;
    logic                             last_reg, done_reg;
    logic [PIX_BITS+WIDTH_BITS-1:0]   row_base;
    logic                             pop_fire;

    assign pop_ready = !out_valid_reg || pixel.ready;
    assign pop_fire  = pop_valid && pop_ready;
    assign row_base  = pop_pix.y * frame_width;
    assign addr_next = ADDR_BITS'(row_base) + ADDR_BITS'(pop_pix.x);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop_ready)
        begin
            out_valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            x_reg      <= pop_pix.x;
            y_reg      <= pop_pix.y;
            addr_reg   <= addr_next;
            colour_reg <= draw_colour;
            last_reg   <= pop_pix.last;
            done_reg   <= pop_pix.done;
        end
    end

    assign pixel.valid         = out_valid_reg;
    assign pixel.pixel_x       = x_reg;
    assign pixel.pixel_y       = y_reg;
    assign pixel.pixel_address = addr_reg;
    assign pixel.pixel_colour  = colour_reg;
    assign pixel.last_of_run   = last_reg;
    assign pixel.line_done     = done_reg;

    // a pending word leaves only when taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pixel.ready && !pop_valid) |=> out_valid_reg)
        else $error("pending pixel dropped");

endmodule

// ===== sv/symmetric_double_step_line_core.sv =====
`timescale 1ns / 1ps
// symmetric_double_step_line_core: top level of the double-step line rasterizer
// depends on sdsl_pkg, sdsl_if, sdsl_front, sdsl_queue, sdsl_back
//
//  channel   dir   handshake     word
//  item      in    valid/ready   mode, x_start, y_start, x_end, y_end
//  pixel     out   valid/ready   pixel_x, pixel_y, pixel_address, pixel_colour,
//                                last_of_run, line_done
//  cfg       in    valid/ready   index, data (0 frame_width, 1 draw_colour)
//
// a start item gives 1 or 2 pixels, a step item up to 4; the front holds the
// next item until its burst register has drained into the queue
// sustained rate is one pixel per cycle, set by the single-pixel output register,
// while items keep coming and the pixel receiver does not stall
// the first pixel of an item goes from the burst register through the queue into the output register
// rst_n clears the line state to idle and the registers to width 320, colour 0
// an output stall backs up through the queue into the front burst register

module symmetric_double_step_line_core
    import sdsl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    sdsl_item_if.sink    item,
    sdsl_pixel_if.source pixel,
    sdsl_cfg_if.sink     cfg
);

    // configuration registers; the user must write them only while the block is idle, the block does not enforce it
    logic [WIDTH_BITS-1:0]  frame_width_reg;
    logic [COLOUR_BITS-1:0] draw_colour_reg;

    // front to queue
    pix_t push_pix;
    logic push_valid, push_ready;

    // queue to back
    pix_t pop_pix;
    logic pop_valid, pop_ready;

    // the configuration port never stalls
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= FRAME_WIDTH_RESET;
            draw_colour_reg <= DRAW_COLOUR_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FRAME_WIDTH: frame_width_reg <= WIDTH_BITS'(cfg.data);
                CFG_DRAW_COLOUR: draw_colour_reg <= cfg.data;
                default:         ;
            endcase
        end
    end

    // front: decode the item, step the cursors, build the pixel burst
    sdsl_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push_pix   (push_pix),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // queue: lets the front run ahead of a stalled output
    sdsl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_pix   (push_pix),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_pix    (pop_pix),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // back: frame address, colour and output register
    sdsl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_pix     (pop_pix),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .frame_width (frame_width_reg),
        .draw_colour (draw_colour_reg),
        .pixel       (pixel)
    );

endmodule

// ===== verif/tb_symmetric_double_step_line_core.sv =====
`timescale 1ns / 1ps
// tb_symmetric_double_step_line_core: self-checking bench for the double-step line core,
// predicts every pixel word from its own line state and checks the pixel channel
// depends on sdsl_pkg, sdsl_if and symmetric_double_step_line_core

module tb_symmetric_double_step_line_core;
    import sdsl_pkg::*;

    localparam int SETTLE_CYCLES = 12;       // idle cycles after the last pixel, above latency
    localparam int DRAIN_LIMIT   = 4000;     // cycles allowed for the final drain
    localparam int WATCHDOG_NS   = 4_000_000;

    // double-step patterns: which of the two sub-steps moves the minor coordinate
    typedef enum int {
        PAT_NONE   = 1,
        PAT_SECOND = 2,
        PAT_FIRST  = 3,
        PAT_BOTH   = 4
    } pattern_t;

    // one expected pixel word
    typedef struct packed {
        logic [PIX_BITS-1:0]    x;
        logic [PIX_BITS-1:0]    y;
        logic [ADDR_BITS-1:0]   addr;
        logic [COLOUR_BITS-1:0] colour;
        logic                   last;
        logic                   done;
    } pixel_word_t;

    logic clk;
    logic rst_n;

    sdsl_item_if  line_item ();
    sdsl_pixel_if pixel_out ();
    sdsl_cfg_if   cfg_wr ();

    symmetric_double_step_line_core #(
        .COORD_BITS (12)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (line_item),
        .pixel (pixel_out),
        .cfg   (cfg_wr)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // line state of the predictor, mirrors what the core keeps
    // ------------------------------------------------------------------
    logic [WIDTH_BITS-1:0]  frame_w        = FRAME_WIDTH_RESET;
    logic [COLOUR_BITS-1:0] draw_colour_r  = DRAW_COLOUR_RESET;
    logic [PIX_BITS-1:0]    lo_major       = '0;  // cursor walking up from the low end
    logic [PIX_BITS-1:0]    lo_minor       = '0;
    logic [PIX_BITS-1:0]    hi_major       = '0;  // cursor walking down from the high end
    logic [PIX_BITS-1:0]    hi_minor       = '0;
    int                     err_acc        = 0;   // decision variable
    int                     err_inc_a      = 0;   // added after patterns 1 and 4
    int                     err_inc_b      = 0;   // added after patterns 2 and 3
    int                     err_split      = 0;   // bound between patterns 2 and 3
    logic                   minor_neg      = 1'b0;
    logic                   xy_swapped     = 1'b0;
    logic                   slope_steep    = 1'b0;
    int                     passes_todo    = 0;
    int                     tail_count     = 0;
    logic                   drawing        = 1'b0;

    pixel_word_t pending_pixels [$];   // expected pixel words, oldest first
    pixel_word_t head_pix;

    // run bookkeeping
    int failures       = 0;
    int items_sent     = 0;
    int lines_started  = 0;
    int pixels_checked = 0;
    int cfg_writes     = 0;

    // idling controls
    logic tx_idling    = 1'b1;
    logic rx_idling    = 1'b1;
    int   rx_hold_left = 0;     // long receiver hold-off, counted down by the ready process
    int   rx_stall_left = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic pixel_word_t make_pixel(logic [PIX_BITS-1:0] major,
                                               logic [PIX_BITS-1:0] minor);
        pixel_word_t p;
        logic [63:0] addr_full;
        p.x = xy_swapped ? minor : major;
        p.y = xy_swapped ? major : minor;
        // address wraps at 24 bits; width 0 leaves x alone
        addr_full = 64'(p.y) * 64'(frame_w) + 64'(p.x);
        p.addr   = addr_full[ADDR_BITS-1:0];
        p.colour = draw_colour_r;
        p.last   = 1'b0;
        p.done   = 1'b0;
        return p;
    endfunction

    function automatic logic [PIX_BITS-1:0] minor_ahead(logic [PIX_BITS-1:0] v);
        return minor_neg ? v - 12'd1 : v + 12'd1;
    endfunction

    function automatic logic [PIX_BITS-1:0] minor_behind(logic [PIX_BITS-1:0] v);
        return minor_neg ? v + 12'd1 : v - 12'd1;
    endfunction

    function automatic pattern_t pick_pattern();
        if (!slope_steep && err_acc < 0)
            return PAT_NONE;
        if (slope_steep && err_acc > 0)
            return PAT_BOTH;
        return (err_acc < err_split) ? PAT_SECOND : PAT_FIRST;
    endfunction

    // advance the line state by one accepted item and queue its pixel words
    function automatic int rasterize_item(logic mode, logic [PIX_BITS-1:0] xs,
                                          logic [PIX_BITS-1:0] ys, logic [PIX_BITS-1:0] xe,
                                          logic [PIX_BITS-1:0] ye);
        int          a1, b1, a2, b2, ddx, ddy, dx, dy, t, n;
        pattern_t    pat;
        logic        first_moves, second_moves, back_moves;
        pixel_word_t burst [BURST_MAX];
        n = 0;
        if (mode == MODE_START)
        begin
            a1 = xs;
            b1 = ys;
            a2 = xe;
            b2 = ye;
            ddx = a2 - a1;
            ddy = b2 - b1;
            dx = (ddx < 0) ? -ddx : ddx;
            dy = (ddy < 0) ? -ddy : ddy;
            minor_neg  = ((ddx < 0) != (ddy < 0));
            xy_swapped = (dy > dx);
            if (xy_swapped)
            begin
                t = a1; a1 = b1; b1 = t;
                t = a2; a2 = b2; b2 = t;
                t = dx; dx = dy; dy = t;
            end
            // order the endpoints along the major axis
            if (a1 > a2)
            begin
                t = a1; a1 = a2; a2 = t;
                t = b1; b1 = b2; b2 = t;
            end
            lo_major = a1[PIX_BITS-1:0];
            lo_minor = b1[PIX_BITS-1:0];
            hi_major = a2[PIX_BITS-1:0];
            hi_minor = b2[PIX_BITS-1:0];
            burst[0] = make_pixel(lo_major, lo_minor);
            n = 1;
            if (dx == 0)
            begin
                // zero-length line: one pixel, nothing left to draw
                drawing     = 1'b0;
                passes_todo = 0;
                tail_count  = 0;
                burst[0].done = 1'b1;
            end
            else
            begin
                burst[1] = make_pixel(hi_major, hi_minor);
                n = 2;
                passes_todo = (dx - 1) / 4;
                tail_count  = (dx - 1) % 4;
                err_inc_b   = 4 * dy - 2 * dx;
                slope_steep = (err_inc_b >= 0);
                if (!slope_steep)
                begin
                    err_split = 2 * dy;
                    err_inc_a = 2 * err_split;
                    err_acc   = err_inc_a - dx;
                end
                else
                begin
                    err_split = 2 * (dy - dx);
                    err_inc_a = 2 * err_split;
                    err_acc   = err_inc_a + dx;
                end
                drawing = (passes_todo != 0 || tail_count != 0);
                burst[1].done = !drawing;
            end
        end
        else
        begin
            // a step with no line in progress is dropped
            if (!drawing)
                return 0;
            pat = pick_pattern();
            first_moves  = (pat == PAT_FIRST || pat == PAT_BOTH);
            second_moves = (pat == PAT_SECOND || pat == PAT_BOTH);
            if (passes_todo != 0)
            begin
                lo_major = lo_major + 12'd1;
                hi_major = hi_major - 12'd1;
                if (first_moves)
                    lo_minor = minor_ahead(lo_minor);
                burst[n] = make_pixel(lo_major, lo_minor);
                n++;
                lo_major = lo_major + 12'd1;
                if (second_moves)
                    lo_minor = minor_ahead(lo_minor);
                burst[n] = make_pixel(lo_major, lo_minor);
                n++;
                if (first_moves)
                    hi_minor = minor_behind(hi_minor);
                burst[n] = make_pixel(hi_major, hi_minor);
                n++;
                hi_major = hi_major - 12'd1;
                if (second_moves)
                    hi_minor = minor_behind(hi_minor);
                burst[n] = make_pixel(hi_major, hi_minor);
                n++;
                err_acc += (pat == PAT_NONE || pat == PAT_BOTH) ? err_inc_a : err_inc_b;
                passes_todo--;
                if (passes_todo == 0 && tail_count == 0)
                begin
                    drawing = 1'b0;
                    burst[n-1].done = 1'b1;
                end
            end
            else if (tail_count != 0)
            begin
                // leftover pixels after the last pass
                back_moves = (pat == PAT_BOTH) ||
                             (pat == PAT_FIRST && (!slope_steep || err_acc > err_split));
                lo_major = lo_major + 12'd1;
                if (first_moves)
                    lo_minor = minor_ahead(lo_minor);
                burst[n] = make_pixel(lo_major, lo_minor);
                n++;
                if (tail_count > 1)
                begin
                    lo_major = lo_major + 12'd1;
                    if (second_moves)
                        lo_minor = minor_ahead(lo_minor);
                    burst[n] = make_pixel(lo_major, lo_minor);
                    n++;
                end
                if (tail_count > 2)
                begin
                    hi_major = hi_major - 12'd1;
                    if (back_moves)
                        hi_minor = minor_behind(hi_minor);
                    burst[n] = make_pixel(hi_major, hi_minor);
                    n++;
                end
                tail_count = 0;
                drawing    = 1'b0;
                burst[n-1].done = 1'b1;
            end
            else
            begin
                drawing = 1'b0;
                return 0;
            end
        end
        burst[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            pending_pixels.push_back(burst[i]);
        return n;
    endfunction

    // ------------------------------------------------------------------
    // pixel checker: every accepted word against the oldest expectation
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && pixel_out.valid === 1'b1 && pixel_out.ready === 1'b1)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("pixel word with nothing pending: x=%0d y=%0d",
                       pixel_out.pixel_x, pixel_out.pixel_y);
                failures++;
            end
            else
            begin
                head_pix = pending_pixels.pop_front();
                check_field("pixel_x", 32'(head_pix.x), 32'(pixel_out.pixel_x));
                check_field("pixel_y", 32'(head_pix.y), 32'(pixel_out.pixel_y));
                check_field("pixel_address", 32'(head_pix.addr), 32'(pixel_out.pixel_address));
                check_field("pixel_colour", head_pix.colour, pixel_out.pixel_colour);
                check_field("last_of_run", 32'(head_pix.last), 32'(pixel_out.last_of_run));
                check_field("line_done", 32'(head_pix.done), 32'(pixel_out.line_done));
                pixels_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // pixel ready: random stall bursts, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        pixel_out.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                pixel_out.ready <= 1'b0;
            end
            else if (rx_stall_left > 0)
            begin
                rx_stall_left--;
                pixel_out.ready <= 1'b0;
            end
            else if (rx_idling && $urandom_range(0, 5) == 0)
            begin
                rx_stall_left = $urandom_range(1, 16) - 1;
                pixel_out.ready <= 1'b0;
            end
            else
            begin
                pixel_out.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // offer one item, optionally after a random gap; valid stays high on return,
    // so the caller either sends again or drops valid at the next falling edge
    task automatic send_item(input logic mode, input logic [PIX_BITS-1:0] xs,
                             input logic [PIX_BITS-1:0] ys, input logic [PIX_BITS-1:0] xe,
                             input logic [PIX_BITS-1:0] ye);
        int gap;
        int produced;
        if (tx_idling && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 16);
            @(negedge clk);
            line_item.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        else
        begin
            @(negedge clk);
        end
        line_item.valid   <= 1'b1;
        line_item.mode    <= mode;
        line_item.x_start <= xs;
        line_item.y_start <= ys;
        line_item.x_end   <= xe;
        line_item.y_end   <= ye;
        @(posedge clk);
        while (line_item.ready !== 1'b1)
            @(posedge clk);
        produced = rasterize_item(mode, xs, ys, xe, ye);
        // steps that hit an idle core are noise and are not counted
        if (mode == MODE_START || produced != 0)
            items_sent++;
        if (mode == MODE_START)
            lines_started++;
    endtask

    // step item; the endpoint fields carry junk the core must ignore
    task automatic send_step();
        send_item(MODE_STEP, 12'($urandom()), 12'($urandom()), 12'($urandom()),
                  12'($urandom()));
    endtask

    // drop valid, wait for every expected word, then give the core time
    // to finish any step that produced nothing
    task automatic wait_for_pixels();
        @(negedge clk);
        line_item.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only with the core idle
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        wait_for_pixels();
        @(negedge clk);
        cfg_wr.valid <= 1'b1;
        cfg_wr.index <= idx;
        cfg_wr.data  <= data;
        @(posedge clk);
        while (cfg_wr.ready !== 1'b1)
            @(posedge clk);
        if (idx == CFG_FRAME_WIDTH)
            frame_w = data[WIDTH_BITS-1:0];
        else if (idx == CFG_DRAW_COLOUR)
            draw_colour_r = data;
        cfg_writes++;
        @(negedge clk);
        cfg_wr.valid <= 1'b0;
    endtask

    // coordinate about off away from base, kept inside the frame
    function automatic logic [PIX_BITS-1:0] near_coord(logic [PIX_BITS-1:0] base, int off);
        int b;
        b = base;
        if ($urandom_range(0, 1) == 1)
        begin
            if (b + off <= 4095)
                return 12'(b + off);
            if (b >= off)
                return 12'(b - off);
        end
        else
        begin
            if (b >= off)
                return 12'(b - off);
            if (b + off <= 4095)
                return 12'(b + off);
        end
        return 12'($urandom_range(0, 4095));
    endfunction

    // one random line: mostly drawn to its end, sometimes dropped early by the
    // next start, sometimes followed by steps that the idle core ignores
    task automatic random_line();
        logic [PIX_BITS-1:0] xs, ys, xe, ye;
        int span, steps, pick, extra;
        pick = $urandom_range(0, 19);
        span = (pick < 13) ? 24 : (pick < 18) ? 160 : 4095;
        xs = 12'($urandom_range(0, 4095));
        ys = 12'($urandom_range(0, 4095));
        xe = near_coord(xs, $urandom_range(0, span));
        ye = near_coord(ys, $urandom_range(0, span));
        send_item(MODE_START, xs, ys, xe, ye);
        steps = passes_todo + ((tail_count != 0) ? 1 : 0);
        pick = $urandom_range(0, 9);
        if (pick == 0 && steps > 1)
            steps = $urandom_range(1, steps - 1);
        // long lines are only started, a few passes, then abandoned
        if (steps > 40)
            steps = $urandom_range(2, 12);
        repeat (steps) send_step();
        if (pick == 1)
        begin
            extra = $urandom_range(1, 2);
            repeat (extra) send_step();
        end
    endtask

    // one register setting followed by random lines
    task automatic run_phase(input logic [WIDTH_BITS-1:0] fw,
                             input logic [COLOUR_BITS-1:0] colour, input int budget);
        int target;
        // upper data bits beyond the width field are junk
        write_register(CFG_FRAME_WIDTH, ($urandom() & 32'hFFFF_E000) | 32'(fw));
        write_register(CFG_DRAW_COLOUR, colour);
        target = items_sent + budget;
        while (items_sent < target)
            random_line();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // hand-picked lines at reset settings: degenerate lengths, frame corners,
    // every leftover count, both axis orders and reversed endpoints
    task automatic test_directed_lines();
        // zero-length line, then a step with no line in progress
        send_item(MODE_START, 12'd5, 12'd5, 12'd5, 12'd5);
        send_step();
        // length one: both ends and done in the start burst
        send_item(MODE_START, 12'd10, 12'd20, 12'd11, 12'd20);
        // corner to corner diagonal, dropped by the next start after two passes
        send_item(MODE_START, 12'd0, 12'd0, 12'd4095, 12'd4095);
        send_step();
        send_step();
        // anti-diagonal, negative minor direction, also dropped
        send_item(MODE_START, 12'd4095, 12'd0, 12'd0, 12'd4095);
        send_step();
        // shallow, one pass and nothing left over
        send_item(MODE_START, 12'd100, 12'd100, 12'd105, 12'd102);
        send_step();
        // vertical with endpoints reversed, one leftover pixel
        send_item(MODE_START, 12'd3, 12'd7, 12'd3, 12'd1);
        send_step();
        send_step();
        // steep half slope going backward, two leftover pixels
        send_item(MODE_START, 12'd20, 12'd10, 12'd13, 12'd14);
        send_step();
        send_step();
        // three leftover pixels at the frame edge
        send_item(MODE_START, 12'd0, 12'd4095, 12'd8, 12'd4090);
        send_step();
        send_step();
        // horizontal along the last row, pattern 1 throughout
        send_item(MODE_START, 12'd4095, 12'd4095, 12'd4087, 12'd4095);
        send_step();
        send_step();
        send_step();
        // sender pauses until all expected words are in
        wait_for_pixels();
    endtask

    // receiver holds off while lines keep coming, so the core backs up
    // and stalls its item input
    task automatic test_output_stall();
        rx_hold_left = 300;
        send_item(MODE_START, 12'd200, 12'd300, 12'd232, 12'd319);
        while (drawing)
            send_step();
        send_item(MODE_START, 12'd1000, 12'd2047, 12'd981, 12'd2000);
        while (drawing)
            send_step();
        wait_for_pixels();
    endtask

    // walk the registers through their extremes and a few random settings
    task automatic test_register_sweep();
        run_phase(13'd1, 32'hFFFF_FFFF, 50);
        run_phase(13'd4096, 32'h0000_0000, 50);
        run_phase(13'd0, $urandom(), 50);           // address degenerates to x
        run_phase(13'd8191, $urandom(), 50);        // address wraps at 24 bits
        run_phase(13'($urandom_range(1, 4096)), $urandom(), 50);
        run_phase(13'd320, $urandom(), 50);
    endtask

    // closing stretch at full rate on both sides
    task automatic test_full_rate_tail();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        run_phase(13'($urandom_range(1, 4096)), $urandom(), 30);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int waited;
        waited = 0;
        rst_n             = 1'b0;
        line_item.valid   = 1'b0;
        line_item.mode    = MODE_START;
        line_item.x_start = '0;
        line_item.y_start = '0;
        line_item.x_end   = '0;
        line_item.y_end   = '0;
        cfg_wr.valid      = 1'b0;
        cfg_wr.index      = CFG_FRAME_WIDTH;
        cfg_wr.data       = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_lines();
        test_output_stall();
        test_register_sweep();
        test_full_rate_tail();

        // let the last words drain, with a bound
        @(negedge clk);
        line_item.valid <= 1'b0;
        while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_pixels.size() != 0)
        begin
            $error("%0d expected pixel words never arrived", pending_pixels.size());
            failures++;
        end
        // catch any stray word after the end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d items over %0d lines, %0d pixel words checked",
                 items_sent, lines_started, pixels_checked);
        $display("%0d register writes, output hold-off and full-rate tail included",
                 cfg_writes);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #(WATCHDOG_NS);
        $display("timeout: run did not complete, %0d words still pending",
                 pending_pixels.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== symmetric_double_step_line_core.f =====
sv/sdsl_pkg.sv
sv/sdsl_if.sv
sv/sdsl_front.sv
sv/sdsl_queue.sv
sv/sdsl_back.sv
sv/symmetric_double_step_line_core.sv
verif/tb_symmetric_double_step_line_core.sv
